[src/agd_pkg.sv]
// ----------------------------------------------------------------------------
// Graph degree core package
// Shared sizes, codes and request types of the graph degree core.
// ----------------------------------------------------------------------------
package agd_pkg;

    localparam int MAX_NODES    = 16;
    localparam int LABEL_BITS   = 16;
    localparam int PORT_LABEL_W = 16;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int DEG_W        = 5;

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int LBL_W = (LABEL_BITS < PORT_LABEL_W) ? LABEL_BITS : PORT_LABEL_W;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [LBL_W-1:0] t_label;
    typedef logic [OP_W-1:0]  t_op;

    localparam t_op OP_ADD_NODE = 3'd0;
    localparam t_op OP_ADD_EDGE = 3'd1;
    localparam t_op OP_MAX_OUT  = 3'd2;
    localparam t_op OP_MAX_IN   = 3'd3;
    localparam t_op OP_ZERO_OUT = 3'd4;
    localparam t_op OP_ZERO_IN  = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_NONE    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EDGE_RD,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic   wr_en;
        t_idx   wr_addr;
        t_label wr_data;
        logic   rd_en;
        t_idx   rd_addr;
    } t_lbl_req;

    typedef struct packed {
        logic rd_en;
        t_idx rd_a;
        t_idx rd_b;
        logic wr_en;
        t_idx wr_a;
        t_idx wr_b;
    } t_deg_req;

    typedef struct packed {
        t_cnt out_deg;
        t_cnt in_deg;
        logic edge_set;
    } t_deg_rsp;

endpackage

[src/agd_label_ram.sv]
// ----------------------------------------------------------------------------
// Node label memory
// One write port and one registered read port holding the node labels.
// ----------------------------------------------------------------------------
module agd_label_ram (
    input  logic              i_clk,
    input  agd_pkg::t_lbl_req i_req,
    output agd_pkg::t_label   o_rd_data
);
    import agd_pkg::*;

    t_label r_mem [MAX_NODES];
    t_label r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/agd_deg_store.sv]
// ----------------------------------------------------------------------------
// Adjacency and degree store
// Adjacency bits with running out-degree and in-degree counts per node.
// ----------------------------------------------------------------------------
module agd_deg_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  agd_pkg::t_deg_req i_req,
    output agd_pkg::t_deg_rsp o_rsp
);
    import agd_pkg::*;

    logic [MAX_NODES-1:0] r_rows [MAX_NODES];
    t_cnt                 r_out_deg [MAX_NODES];
    t_cnt                 r_in_deg [MAX_NODES];
    t_cnt                 r_out_q;
    t_cnt                 r_in_q;
    logic                 r_bit_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                r_rows[i]    <= '0;
                r_out_deg[i] <= '0;
                r_in_deg[i]  <= '0;
            end
        end else if (i_req.wr_en && !r_bit_q) begin
            r_rows[i_req.wr_a][i_req.wr_b] <= 1'b1;
            r_out_deg[i_req.wr_a]          <= r_out_q + t_cnt'(1);
            r_in_deg[i_req.wr_b]           <= r_in_q + t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_out_q <= r_out_deg[i_req.rd_a];
            r_in_q  <= r_in_deg[i_req.rd_b];
            r_bit_q <= r_rows[i_req.rd_a][i_req.rd_b];
        end
    end

    assign o_rsp.out_deg  = r_out_q;
    assign o_rsp.in_deg   = r_in_q;
    assign o_rsp.edge_set = r_bit_q;

endmodule

[src/adjacency_matrix_graph_degrees_core.sv]
// ----------------------------------------------------------------------------
// Graph degree core
// Directed graph store answering node, edge and degree requests.
// ----------------------------------------------------------------------------
// An add node request goes straight to the finish state and is answered
// there. Add edge and the four degree queries walk the node table one
// entry per cycle, unless a zero degree query is held by a stalled result
// side, through the single read port of the label memory and the degree
// store. An add edge that finds both endpoints reads the degree store once
// more before its result.
// One request is worked on at a time and o_in_stall stays high until its
// final result beat has been loaded into the output register. The zero
// degree queries deliver one beat per matching node, the last one flagged.
// Reset clears the node count and the adjacency store at once.
module adjacency_matrix_graph_degrees_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [agd_pkg::OP_W-1:0]          i_op,
    input  logic [agd_pkg::PORT_LABEL_W-1:0]  i_label_a,
    input  logic [agd_pkg::PORT_LABEL_W-1:0]  i_label_b,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [agd_pkg::STATUS_W-1:0]      o_status,
    output logic [agd_pkg::PORT_LABEL_W-1:0]  o_node_label,
    output logic [agd_pkg::DEG_W-1:0]         o_degree,
    output logic                              o_last
);
    import agd_pkg::*;

    t_state  r_state, n_state;
    t_op     r_op, n_op;
    t_label  r_la, n_la;
    t_label  r_lb, n_lb;
    t_cnt    r_idx, n_idx;
    t_cnt    r_count, n_count;
    logic    r_rd_vld, n_rd_vld;
    t_idx    r_rd_idx, n_rd_idx;
    logic    r_fa, n_fa;
    logic    r_fb, n_fb;
    t_idx    r_sidx, n_sidx;
    t_idx    r_didx, n_didx;
    t_cnt    r_best, n_best;
    t_label  r_best_lab, n_best_lab;
    logic    r_pend_vld, n_pend_vld;
    t_label  r_pend_lab, n_pend_lab;
    logic    r_out_vld, n_out_vld;
    t_status r_out_status, n_out_status;
    t_label  r_out_label, n_out_label;
    t_cnt    r_out_deg, n_out_deg;
    logic    r_out_last, n_out_last;

    t_lbl_req lbl_req;
    t_label   lbl_q;
    t_deg_req deg_req;
    t_deg_rsp deg_rsp;

    logic accept;
    logic out_ready;
    logic issue;
    logic is_in_dir;
    logic is_zero_op;
    logic is_max_op;
    t_cnt deg_q;
    logic freeze;

    agd_label_ram u_label_ram (
        .i_clk     (i_clk),
        .i_req     (lbl_req),
        .o_rd_data (lbl_q)
    );

    agd_deg_store u_deg_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (deg_req),
        .o_rsp   (deg_rsp)
    );

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_ready  = !r_out_vld || !i_out_stall;
    assign issue      = (r_idx < r_count);
    assign is_in_dir  = (r_op == OP_MAX_IN) || (r_op == OP_ZERO_IN);
    assign is_zero_op = (r_op == OP_ZERO_OUT) || (r_op == OP_ZERO_IN);
    assign is_max_op  = (r_op == OP_MAX_OUT) || (r_op == OP_MAX_IN);
    assign deg_q      = is_in_dir ? deg_rsp.in_deg : deg_rsp.out_deg;
    assign freeze     = (r_state == S_SCAN) && r_rd_vld && is_zero_op &&
                        (deg_q == '0) && r_pend_vld && !out_ready;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_la         = r_la;
        n_lb         = r_lb;
        n_idx        = r_idx;
        n_count      = r_count;
        n_rd_vld     = r_rd_vld;
        n_rd_idx     = r_rd_idx;
        n_fa         = r_fa;
        n_fb         = r_fb;
        n_sidx       = r_sidx;
        n_didx       = r_didx;
        n_best       = r_best;
        n_best_lab   = r_best_lab;
        n_pend_vld   = r_pend_vld;
        n_pend_lab   = r_pend_lab;
        n_out_vld    = r_out_vld && i_out_stall;
        n_out_status = r_out_status;
        n_out_label  = r_out_label;
        n_out_deg    = r_out_deg;
        n_out_last   = r_out_last;

        lbl_req         = '0;
        lbl_req.wr_addr = r_count[IDX_W-1:0];
        lbl_req.wr_data = r_la;
        lbl_req.rd_addr = r_idx[IDX_W-1:0];
        deg_req         = '0;
        deg_req.rd_a    = r_idx[IDX_W-1:0];
        deg_req.rd_b    = r_idx[IDX_W-1:0];
        deg_req.wr_a    = r_sidx;
        deg_req.wr_b    = r_didx;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op       = i_op;
                    n_la       = i_label_a[LBL_W-1:0];
                    n_lb       = i_label_b[LBL_W-1:0];
                    n_idx      = '0;
                    n_rd_vld   = 1'b0;
                    n_fa       = 1'b0;
                    n_fb       = 1'b0;
                    n_best     = '0;
                    n_best_lab = '0;
                    n_pend_vld = 1'b0;
                    if (i_op == OP_ADD_NODE) begin
                        n_state = S_FINISH;
                    end else if (i_op <= OP_ZERO_IN) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!freeze) begin
                    lbl_req.rd_en = issue;
                    deg_req.rd_en = issue;
                    n_rd_vld      = issue;
                    n_rd_idx      = r_idx[IDX_W-1:0];
                    if (issue) begin
                        n_idx = r_idx + t_cnt'(1);
                    end
                    if (r_rd_vld) begin
                        if (r_op == OP_ADD_EDGE) begin
                            if (!r_fa && (lbl_q == r_la)) begin
                                n_fa   = 1'b1;
                                n_sidx = r_rd_idx;
                            end
                            if (!r_fb && (lbl_q == r_lb)) begin
                                n_fb   = 1'b1;
                                n_didx = r_rd_idx;
                            end
                        end else if (is_max_op) begin
                            if (deg_q > r_best) begin
                                n_best     = deg_q;
                                n_best_lab = lbl_q;
                            end
                        end else if (deg_q == '0) begin
                            if (r_pend_vld) begin
                                n_out_vld    = 1'b1;
                                n_out_status = ST_OK;
                                n_out_label  = r_pend_lab;
                                n_out_deg    = '0;
                                n_out_last   = 1'b0;
                            end
                            n_pend_vld = 1'b1;
                            n_pend_lab = lbl_q;
                        end
                    end
                    if (!issue && !r_rd_vld) begin
                        if ((r_op == OP_ADD_EDGE) && r_fa && r_fb) begin
                            n_state = S_EDGE_RD;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                end
            end
            S_EDGE_RD: begin
                deg_req.rd_en = 1'b1;
                deg_req.rd_a  = r_sidx;
                deg_req.rd_b  = r_didx;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (out_ready) begin
                    n_out_vld   = 1'b1;
                    n_out_label = '0;
                    n_out_deg   = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                    if (r_op == OP_ADD_NODE) begin
                        if (r_count == t_cnt'(MAX_NODES)) begin
                            n_out_status = ST_FULL;
                        end else begin
                            lbl_req.wr_en = 1'b1;
                            n_count       = r_count + t_cnt'(1);
                            n_out_status  = ST_OK;
                        end
                    end else if (r_op == OP_ADD_EDGE) begin
                        if (r_fa && r_fb) begin
                            deg_req.wr_en = 1'b1;
                            n_out_status  = ST_OK;
                        end else begin
                            n_out_status = ST_MISSING;
                        end
                    end else if (is_max_op) begin
                        if (r_best == '0) begin
                            n_out_status = ST_NONE;
                        end else begin
                            n_out_status = ST_OK;
                            n_out_label  = r_best_lab;
                            n_out_deg    = r_best;
                        end
                    end else begin
                        if (r_pend_vld) begin
                            n_out_status = ST_OK;
                            n_out_label  = r_pend_lab;
                        end else begin
                            n_out_status = ST_NONE;
                        end
                        n_pend_vld = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rd_vld   <= n_rd_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_la         <= n_la;
        r_lb         <= n_lb;
        r_idx        <= n_idx;
        r_rd_idx     <= n_rd_idx;
        r_fa         <= n_fa;
        r_fb         <= n_fb;
        r_sidx       <= n_sidx;
        r_didx       <= n_didx;
        r_best       <= n_best;
        r_best_lab   <= n_best_lab;
        r_pend_lab   <= n_pend_lab;
        r_out_status <= n_out_status;
        r_out_label  <= n_out_label;
        r_out_deg    <= n_out_deg;
        r_out_last   <= n_out_last;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_status     = r_out_status;
    assign o_node_label = PORT_LABEL_W'(r_out_label);
    assign o_degree     = DEG_W'(r_out_deg);
    assign o_last       = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(MAX_NODES))
        else $error("node count beyond table size");

    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rd_vld)
        else $error("read beat outstanding while idle");

    a_pend_zero_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> ((r_op == OP_ZERO_OUT) || (r_op == OP_ZERO_IN)))
        else $error("pending label outside a zero degree query");

    a_edge_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE_RD) |-> (r_fa && r_fb))
        else $error("edge update without both endpoints");

    a_count_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past((r_state == S_FINISH) &&
                                              (r_op == OP_ADD_NODE)))
        else $error("node count changed outside add node");

endmodule
